/* sv/acec_pkg.sv */
// ============================================================================
// acec_pkg: shared definitions for the alarm code entry controller
// Widths, codes and word types used across the controller's modules.
// ============================================================================
package acec_pkg;

    // Code length and field widths
    localparam int CODE_LENGTH = 3;
    localparam int DIGIT_W     = 4;
    localparam int COUNT_W     = 2;
    localparam int TIMEOUT_W   = 16;

    // Digit constants
    localparam logic [DIGIT_W-1:0] EMPTY_MARK = 4'hF;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 4'd1;

    // Configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_DIGIT_TIMEOUT = 2'd0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;

    // Event codes reported with each result word
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_ARMED    = 2'd1,
        EV_DISARMED = 2'd2,
        EV_REJECTED = 2'd3
    } t_event;

    // Digit closed by the press counter on the current tick
    typedef struct packed {
        logic               close;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    // One result word
    typedef struct packed {
        logic               armed;
        logic               alert;
        logic               digit_valid;
        logic [DIGIT_W-1:0] digit_value;
        logic [COUNT_W-1:0] digits_entered;
        t_event             code_event;
    } t_result;

endpackage

/* sv/acec_if.sv */
// ============================================================================
// acec_if: handshake channels of the alarm code entry controller
// Tick input channel and result output channel, valid/ready with payload.
// ============================================================================

// Tick channel: one word per tick carrying the latched events.
interface acec_tick_if;
    logic valid;
    logic ready;
    logic button_press;
    logic presence_seen;

    modport source (output valid, output button_press, output presence_seen, input ready);
    modport sink   (input valid, input button_press, input presence_seen, output ready);
endinterface

// Result channel: one word per accepted tick.
interface acec_result_if;
    logic                        valid;
    logic                        ready;
    logic                        armed;
    logic                        alert;
    logic                        digit_valid;
    logic [acec_pkg::DIGIT_W-1:0] digit_value;
    logic [acec_pkg::COUNT_W-1:0] digits_entered;
    logic [1:0]                  code_event;

    modport source (output valid, output armed, output alert, output digit_valid,
                    output digit_value, output digits_entered, output code_event,
                    input ready);
    modport sink   (input valid, input armed, input alert, input digit_valid,
                    input digit_value, input digits_entered, input code_event,
                    output ready);
endinterface

/* sv/acec_cfg.sv */
// ============================================================================
// acec_cfg: configuration register block
// APB-style port holding the digit timeout register.
// ============================================================================
module acec_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [acec_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [acec_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [acec_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [acec_pkg::TIMEOUT_W-1:0]      o_timeout
);

    logic [acec_pkg::TIMEOUT_W-1:0] r_timeout;
    logic                           wr_en;

    // The access phase of every transfer completes with no wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == acec_pkg::REG_DIGIT_TIMEOUT);

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= acec_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            r_timeout <= pwdata[acec_pkg::TIMEOUT_W-1:0];
        end
    end

    // Read back; addresses outside the map read as zero.
    always_comb begin
        if (paddr == acec_pkg::REG_DIGIT_TIMEOUT) begin
            prdata = {{(acec_pkg::APB_DATA_W-acec_pkg::TIMEOUT_W){1'b0}}, r_timeout};
        end else begin
            prdata = '0;
        end
    end

    assign o_timeout = r_timeout;

endmodule

/* sv/acec_digit.sv */
// ============================================================================
// acec_digit: press counter
// Counts button presses in a burst, modulo ten, and closes the digit once
// the timeout has passed with no press.
// ============================================================================
module acec_digit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_button,
    input  logic [acec_pkg::TIMEOUT_W-1:0]  i_timeout,
    output acec_pkg::t_digit                o_digit
);

    logic                           r_counting, n_counting;
    logic [acec_pkg::DIGIT_W-1:0]   r_count, n_count;
    logic [acec_pkg::TIMEOUT_W-1:0] r_idle, n_idle;
    logic                           r_pending, n_pending;
    logic                           button;
    logic                           timed_out;
    logic [acec_pkg::TIMEOUT_W-1:0] idle_inc;

    // Press latched this tick or earlier.
    assign button   = r_pending || i_button;
    // Idle counter saturates at its full value.
    assign idle_inc  = (&r_idle) ? r_idle : r_idle + 1'b1;
    assign timed_out = idle_inc >= i_timeout;

    // Next state of the burst counter.
    always_comb begin
        n_counting    = r_counting;
        n_count       = r_count;
        n_idle        = r_idle;
        n_pending     = button;
        o_digit.close = 1'b0;
        o_digit.value = '0;
        if (!r_counting) begin
            if (button) begin
                n_pending  = 1'b0;
                n_count    = acec_pkg::DIGIT_ONE;
                n_idle     = '0;
                n_counting = 1'b1;
            end
        end else begin
            n_idle = idle_inc;
            if (button && !timed_out) begin
                n_pending = 1'b0;
                n_count   = (r_count >= acec_pkg::DIGIT_MAX) ? '0 : r_count + 1'b1;
                n_idle    = '0;
            end else if (timed_out) begin
                o_digit.close = 1'b1;
                o_digit.value = r_count;
                n_count       = '0;
                n_counting    = 1'b0;
            end
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counting <= 1'b0;
            r_count    <= '0;
            r_idle     <= '0;
            r_pending  <= 1'b0;
        end else if (i_step) begin
            r_counting <= n_counting;
            r_count    <= n_count;
            r_idle     <= n_idle;
            r_pending  <= n_pending;
        end
    end

endmodule

/* sv/acec_code.sv */
// ============================================================================
// acec_code: code state machine
// Collects digits into a code, arms, disarms or rejects, and raises the
// intrusion alert; builds the result word of each tick.
// ============================================================================
module acec_code (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_presence,
    input  acec_pkg::t_digit    i_digit,
    output acec_pkg::t_result   o_result
);

    typedef enum logic [7:0] {
        ST_DISARMED      = 8'b0000_0001,
        ST_COLLECT       = 8'b0000_0010,
        ST_CHECK         = 8'b0000_0100,
        ST_ARMED         = 8'b0000_1000,
        ST_NOT_OK        = 8'b0001_0000,
        ST_ALERT_COLLECT = 8'b0010_0000,
        ST_ALERT_ARMED   = 8'b0100_0000,
        ST_ALERT_NOT_OK  = 8'b1000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [acec_pkg::DIGIT_W-1:0]   r_entered [acec_pkg::CODE_LENGTH];
    logic [acec_pkg::DIGIT_W-1:0]   n_entered [acec_pkg::CODE_LENGTH];
    logic [acec_pkg::DIGIT_W-1:0]   r_stored  [acec_pkg::CODE_LENGTH];
    logic [acec_pkg::DIGIT_W-1:0]   n_stored  [acec_pkg::CODE_LENGTH];
    logic [acec_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                           r_dig_pending, n_dig_pending;
    logic [acec_pkg::DIGIT_W-1:0]   r_held, n_held;
    logic                           r_pres_pending, n_pres_pending;
    logic                           r_accepted, n_accepted;
    logic                           r_armed, n_armed;
    logic                           r_alert, n_alert;
    logic [acec_pkg::DIGIT_W-1:0]   fill [acec_pkg::CODE_LENGTH];
    logic [acec_pkg::COUNT_W:0]     count_inc;
    logic                           code_full;
    logic                           match;
    logic                           do_take;
    logic                           do_alert;
    acec_pkg::t_event               event_code;

    // Code as it stands once the held digit is written at the entry slot.
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < acec_pkg::CODE_LENGTH; i++) begin
            fill[i] = (acec_pkg::COUNT_W'(i) == r_count) ? n_held : r_entered[i];
            if (fill[i] != r_stored[i]) begin
                match = 1'b0;
            end
        end
    end

    assign count_inc = {1'b0, r_count} + 1'b1;
    assign code_full = count_inc >= (acec_pkg::COUNT_W+1)'(acec_pkg::CODE_LENGTH);

    // Code machine next state.
    always_comb begin
        n_state        = r_state;
        n_entered      = r_entered;
        n_stored       = r_stored;
        n_count        = r_count;
        n_dig_pending  = r_dig_pending || i_digit.close;
        n_held         = i_digit.close ? i_digit.value : r_held;
        n_pres_pending = r_pres_pending || i_presence;
        n_accepted     = r_accepted;
        n_armed        = r_armed;
        n_alert        = r_alert;
        event_code     = acec_pkg::EV_NONE;
        do_take        = 1'b0;
        do_alert       = 1'b0;

        case (r_state)
            ST_COLLECT: begin
                if (n_dig_pending) begin
                    do_take = 1'b1;
                end else if (r_armed && n_pres_pending) begin
                    do_alert = 1'b1;
                    n_state  = ST_ALERT_COLLECT;
                end
            end
            ST_CHECK: begin
                if (r_armed && r_accepted) begin
                    n_armed    = 1'b0;
                    n_alert    = 1'b0;
                    n_stored   = '{default: acec_pkg::EMPTY_MARK};
                    n_entered  = '{default: acec_pkg::EMPTY_MARK};
                    n_accepted = 1'b0;
                    event_code = acec_pkg::EV_DISARMED;
                    n_state    = ST_DISARMED;
                end else if (!r_armed && r_accepted) begin
                    n_armed    = 1'b1;
                    n_stored   = r_entered;
                    n_entered  = '{default: acec_pkg::EMPTY_MARK};
                    n_accepted = 1'b0;
                    event_code = acec_pkg::EV_ARMED;
                    n_state    = ST_ARMED;
                end else begin
                    n_entered  = '{default: acec_pkg::EMPTY_MARK};
                    event_code = acec_pkg::EV_REJECTED;
                    n_state    = ST_NOT_OK;
                end
            end
            ST_ARMED: begin
                if (r_armed && n_pres_pending) begin
                    do_alert = 1'b1;
                    n_state  = ST_ALERT_ARMED;
                end else if (n_dig_pending) begin
                    do_take = 1'b1;
                end
            end
            ST_NOT_OK: begin
                if (r_armed && n_pres_pending) begin
                    do_alert = 1'b1;
                    n_state  = ST_ALERT_NOT_OK;
                end else if (n_dig_pending) begin
                    do_take = 1'b1;
                end
            end
            ST_ALERT_COLLECT: begin
                n_state = ST_COLLECT;
            end
            ST_ALERT_ARMED: begin
                n_state = ST_ARMED;
            end
            ST_ALERT_NOT_OK: begin
                n_state = ST_NOT_OK;
            end
            default: begin
                n_state = ST_DISARMED;
                if (n_dig_pending) begin
                    do_take = 1'b1;
                end
            end
        endcase

        // Presence while armed raises the alert and consumes the event.
        if (do_alert) begin
            n_alert        = 1'b1;
            n_pres_pending = 1'b0;
        end

        // Take the held digit into the code; a full code goes to the check.
        if (do_take) begin
            n_entered     = fill;
            n_dig_pending = 1'b0;
            if (code_full) begin
                n_accepted = r_armed ? match : 1'b1;
                n_count    = '0;
                n_state    = ST_CHECK;
            end else begin
                n_count = count_inc[acec_pkg::COUNT_W-1:0];
                n_state = ST_COLLECT;
            end
        end
    end

    // Result word of this tick.
    always_comb begin
        o_result.armed          = n_armed;
        o_result.alert          = n_alert;
        o_result.digit_valid    = i_digit.close;
        o_result.digit_value    = i_digit.value;
        o_result.digits_entered = n_count;
        o_result.code_event     = event_code;
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_DISARMED;
            r_entered      <= '{default: acec_pkg::EMPTY_MARK};
            r_stored       <= '{default: acec_pkg::EMPTY_MARK};
            r_count        <= '0;
            r_dig_pending  <= 1'b0;
            r_held         <= '0;
            r_pres_pending <= 1'b0;
            r_accepted     <= 1'b0;
            r_armed        <= 1'b0;
            r_alert        <= 1'b0;
        end else if (i_step) begin
            r_state        <= n_state;
            r_entered      <= n_entered;
            r_stored       <= n_stored;
            r_count        <= n_count;
            r_dig_pending  <= n_dig_pending;
            r_held         <= n_held;
            r_pres_pending <= n_pres_pending;
            r_accepted     <= n_accepted;
            r_armed        <= n_armed;
            r_alert        <= n_alert;
        end
    end

endmodule

/* sv/acec_obuf.sv */
// ============================================================================
// acec_obuf: result output buffer
// Output register with a skid stage, so that a tick is taken while a
// finished result word still waits downstream.
// ============================================================================
module acec_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  acec_pkg::t_result   i_word,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_pop_ready,
    output acec_pkg::t_result   o_word
);

    logic              r_out_valid;
    logic              r_skid_valid;
    acec_pkg::t_result r_out;
    acec_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_out_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_valid ? r_skid : i_word;
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= i_word;
            end else begin
                r_out <= i_word;
            end
        end
    end

endmodule

/* sv/alarm_code_entry_controller_core.sv */
// ============================================================================
// alarm_code_entry_controller_core: keypad code lock and alarm controller
// Press counter, code state machine and buffered result channel.
// ============================================================================
//
//  Channel   Direction  Word                               Handshake
//  i_tick    in         button_press, presence_seen        valid / ready
//  o_result  out        armed, alert, digit_valid,         valid / ready
//                       digit_value, digits_entered,
//                       code_event
//  APB       in         digit timeout register (addr 0)    psel/penable, pready
//
// Each accepted tick updates all state as it is taken; its result word is
// registered at the output or skid stage; one tick per cycle while ready.
// The skid stage lets one more tick in while the output is stalled; ready
// drops only when both output stages are full.
// Reset is synchronous and active low; it clears the state and the buffer,
// and sets the timeout to 200 ticks.
//
module alarm_code_entry_controller_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    acec_tick_if.sink                       i_tick,
    acec_result_if.source                   o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [acec_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [acec_pkg::APB_DATA_W-1:0] pwdata,
    output logic [acec_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [acec_pkg::TIMEOUT_W-1:0] timeout;
    logic                           step;
    logic                           buf_ready;
    acec_pkg::t_digit               digit;
    acec_pkg::t_result              word;
    acec_pkg::t_result              out_word;

    // A tick is taken whenever the buffer has room.
    assign i_tick.ready = buf_ready;
    assign step         = i_tick.valid && buf_ready;

    // Configuration registers.
    acec_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (timeout)
    );

    // Press counter.
    acec_digit u_digit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_button  (i_tick.button_press),
        .i_timeout (timeout),
        .o_digit   (digit)
    );

    // Code state machine.
    acec_code u_code (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_presence (i_tick.presence_seen),
        .i_digit    (digit),
        .o_result   (word)
    );

    // Output register and skid stage.
    acec_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (step),
        .i_word      (word),
        .o_ready     (buf_ready),
        .o_valid     (o_result.valid),
        .i_pop_ready (o_result.ready),
        .o_word      (out_word)
    );

    // Result word onto the channel.
    assign o_result.armed          = out_word.armed;
    assign o_result.alert          = out_word.alert;
    assign o_result.digit_valid    = out_word.digit_valid;
    assign o_result.digit_value    = out_word.digit_value;
    assign o_result.digits_entered = out_word.digits_entered;
    assign o_result.code_event     = out_word.code_event;

endmodule

/* sv/acec_checker.sv */
// ============================================================================
// acec_checker: port checks for the alarm code entry controller
// Concurrent assertions on the result channel, bound to the top level.
// ============================================================================
module acec_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_armed,
    input logic                         i_alert,
    input logic                         i_digit_valid,
    input logic [acec_pkg::DIGIT_W-1:0] i_digit_value,
    input logic [1:0]                   i_code_event
);

    // Reset empties the result channel.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_armed)
            && $stable(i_alert) && $stable(i_digit_value) && $stable(i_code_event))
        else $error("stalled result word changed");

    // The alert is only ever raised while armed.
    a_alert_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_alert |-> i_armed)
        else $error("alert without armed");

    // Arm and disarm events agree with the armed flag and carry no alert.
    a_event_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_code_event == acec_pkg::EV_ARMED
            || i_code_event == acec_pkg::EV_DISARMED)
        |-> (i_armed == (i_code_event == acec_pkg::EV_ARMED)) && !i_alert)
        else $error("event disagrees with armed or alert flag");

    // No digit value without a closed digit.
    a_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_digit_valid |-> i_digit_value == '0)
        else $error("digit value without digit valid");

endmodule

bind alarm_code_entry_controller_core acec_checker u_acec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_armed       (o_result.armed),
    .i_alert       (o_result.alert),
    .i_digit_valid (o_result.digit_valid),
    .i_digit_value (o_result.digit_value),
    .i_code_event  (o_result.code_event)
);

/* bench/testbench.sv */
// ============================================================================
// testbench: self-checking bench for the alarm code entry controller
// Feeds tick words from a planned queue, predicts each status word with an
// in-bench model of the press counter and the code machine, and checks every
// result word field by field under random gaps, stalls and timeout settings.
// ============================================================================
module testbench;
    import acec_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 64;
    localparam int HOLD_EVERY   = 700;
    localparam int PHASE_ITEMS  = 110;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = 16'hFFFF;

    // Code machine states of the lock model.
    typedef enum logic [3:0] {
        LS_DISARMED      = 4'd0,
        LS_COLLECT       = 4'd1,
        LS_CHECK         = 4'd2,
        LS_ARMED         = 4'd3,
        LS_NOT_OK        = 4'd4,
        LS_ALERT_COLLECT = 4'd5,
        LS_ALERT_ARMED   = 4'd6,
        LS_ALERT_NOT_OK  = 4'd7
    } t_lock_state;

    typedef struct packed {
        logic press;
        logic presence;
    } t_tick_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    acec_tick_if   tick_ch();
    acec_result_if result_ch();

    alarm_code_entry_controller_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Lock model state.
    logic [TIMEOUT_W-1:0] lock_timeout;
    logic                 counting;
    logic [DIGIT_W-1:0]   press_total;
    logic [TIMEOUT_W-1:0] quiet_ticks;
    logic                 press_latched;
    logic                 presence_latched;
    logic                 digit_waiting;
    logic [DIGIT_W-1:0]   waiting_digit;
    t_lock_state          lock_state;
    logic [DIGIT_W-1:0]   entry_digits [CODE_LENGTH];
    logic [DIGIT_W-1:0]   stored_digits [CODE_LENGTH];
    int                   entry_count;
    logic                 code_ok;
    logic                 armed_now;
    logic                 alert_now;

    // Planned tick words and predicted status words.
    t_tick_word tick_plan[$];
    t_result    predicted_status[$];
    t_tick_word offered;

    int ticks_queued   = 0;
    int ticks_accepted = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int digits_closed  = 0;
    int arms_seen      = 0;
    int disarms_seen   = 0;
    int rejects_seen   = 0;
    int alerts_raised  = 0;
    int timeouts_used  = 0;

    // Clock generation.
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long, and now and then a
    // steady stretch with no gaps at all.
    function automatic int pick_gap(inout int steady);
        int r;
        if (steady > 0) begin
            steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            steady = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void clear_entry();
        for (int i = 0; i < CODE_LENGTH; i++) entry_digits[i] = EMPTY_MARK;
    endfunction

    // Hands the held digit to the code machine; the last one of a code moves
    // it to the check state with the verdict already worked out.
    function automatic void take_digit();
        if (entry_count < CODE_LENGTH) entry_digits[entry_count] = waiting_digit;
        entry_count++;
        if (entry_count >= CODE_LENGTH) begin
            code_ok = 1'b1;
            if (armed_now) begin
                for (int i = 0; i < CODE_LENGTH; i++)
                    if (entry_digits[i] != stored_digits[i]) code_ok = 1'b0;
            end
            entry_count = 0;
            lock_state  = LS_CHECK;
        end else begin
            lock_state = LS_COLLECT;
        end
        digit_waiting = 1'b0;
    endfunction

    // Presence raises the alert only while armed; otherwise it stays latched.
    function automatic logic raise_alert();
        if (armed_now && presence_latched) begin
            alert_now        = 1'b1;
            presence_latched = 1'b0;
            alerts_raised++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the lock model by one tick and returns the status word it gives.
    function automatic t_result predict_status(input t_tick_word w);
        t_result r;
        logic    timed_out;
        r = '0;
        if (w.press) press_latched = 1'b1;
        if (w.presence) presence_latched = 1'b1;

        // Press counter.
        if (!counting) begin
            if (press_latched) begin
                press_latched = 1'b0;
                press_total   = DIGIT_ONE;
                quiet_ticks   = '0;
                counting      = 1'b1;
            end
        end else begin
            if (quiet_ticks != TIMEOUT_MAX) quiet_ticks++;
            timed_out = quiet_ticks >= lock_timeout;
            if (press_latched && !timed_out) begin
                press_latched = 1'b0;
                press_total   = (press_total >= DIGIT_MAX) ? '0 : press_total + 1'b1;
                quiet_ticks   = '0;
            end else if (timed_out) begin
                r.digit_valid = 1'b1;
                r.digit_value = press_total;
                waiting_digit = press_total;
                digit_waiting = 1'b1;
                press_total   = '0;
                counting      = 1'b0;
                digits_closed++;
            end
        end

        // Code machine.
        r.code_event = EV_NONE;
        case (lock_state)
            LS_COLLECT: begin
                if (digit_waiting) take_digit();
                else if (raise_alert()) lock_state = LS_ALERT_COLLECT;
            end
            LS_CHECK: begin
                if (armed_now && code_ok) begin
                    armed_now = 1'b0;
                    alert_now = 1'b0;
                    for (int i = 0; i < CODE_LENGTH; i++) stored_digits[i] = EMPTY_MARK;
                    clear_entry();
                    code_ok      = 1'b0;
                    r.code_event = EV_DISARMED;
                    lock_state   = LS_DISARMED;
                    disarms_seen++;
                end else if (!armed_now && code_ok) begin
                    armed_now = 1'b1;
                    for (int i = 0; i < CODE_LENGTH; i++) stored_digits[i] = entry_digits[i];
                    clear_entry();
                    code_ok      = 1'b0;
                    r.code_event = EV_ARMED;
                    lock_state   = LS_ARMED;
                    arms_seen++;
                end else begin
                    clear_entry();
                    r.code_event = EV_REJECTED;
                    lock_state   = LS_NOT_OK;
                    rejects_seen++;
                end
            end
            LS_ARMED: begin
                if (raise_alert()) lock_state = LS_ALERT_ARMED;
                else if (digit_waiting) take_digit();
            end
            LS_NOT_OK: begin
                if (raise_alert()) lock_state = LS_ALERT_NOT_OK;
                else if (digit_waiting) take_digit();
            end
            LS_ALERT_COLLECT: lock_state = LS_COLLECT;
            LS_ALERT_ARMED:   lock_state = LS_ARMED;
            LS_ALERT_NOT_OK:  lock_state = LS_NOT_OK;
            default: begin
                lock_state = LS_DISARMED;
                if (digit_waiting) take_digit();
            end
        endcase

        r.armed          = armed_now;
        r.alert          = alert_now;
        r.digits_entered = entry_count[COUNT_W-1:0];
        return r;
    endfunction

    // Receiver state, shared with the driver.
    int   rx_gap      = 0;
    int   rx_steady   = 0;
    int   rx_hold     = 0;
    int   rx_cycles   = 0;
    logic rx_long_hold = 1'b0;

    // Tick driver: offers planned words with random gaps, none while the
    // receiver is in a long hold-off, and predicts each accepted word.
    int driver_gap    = 0;
    int driver_steady = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
        end else begin
            if (tick_ch.valid && tick_ch.ready) begin
                predicted_status.push_back(predict_status(offered));
                ticks_accepted++;
            end
            if (!tick_ch.valid || tick_ch.ready) begin
                if (driver_gap > 0 && !rx_long_hold) begin
                    driver_gap--;
                    tick_ch.valid <= 1'b0;
                end else if (tick_plan.size() > 0) begin
                    offered = tick_plan.pop_front();
                    tick_ch.valid         <= 1'b1;
                    tick_ch.button_press  <= offered.press;
                    tick_ch.presence_seen <= offered.presence;
                    driver_gap = pick_gap(driver_steady);
                end else begin
                    tick_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off every so often so
    // that the controller fills up and stops taking ticks.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            rx_long_hold    <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_hold > 0) begin
                rx_hold--;
                result_ch.ready <= 1'b0;
                rx_long_hold    <= (rx_hold > 0);
            end else if (rx_cycles % HOLD_EVERY == 0) begin
                rx_hold = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
                rx_long_hold    <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                rx_gap = pick_gap(rx_steady);
            end
        end
    end

    task automatic check_field(input string name, input logic [3:0] want_v,
                               input logic [3:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    // Result monitor: each accepted word against the oldest prediction.
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (predicted_status.size() == 0) begin
                $display("%0t: result word arrived with nothing predicted", $time);
                error_count++;
            end else begin
                want = predicted_status.pop_front();
                check_field("armed", want.armed, result_ch.armed);
                check_field("alert", want.alert, result_ch.alert);
                check_field("digit_valid", want.digit_valid, result_ch.digit_valid);
                check_field("digit_value", want.digit_value, result_ch.digit_value);
                check_field("digits_entered", want.digits_entered, result_ch.digits_entered);
                check_field("code_event", want.code_event, result_ch.code_event);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_tick(input logic press, input logic presence);
        tick_plan.push_back('{press: press, presence: presence});
        ticks_queued++;
    endtask

    function automatic logic rare_presence();
        return ($urandom_range(0, 39) == 0);
    endfunction

    task automatic wait_drained();
        wait (ticks_accepted == ticks_queued && results_seen >= ticks_queued);
    endtask

    // Writes the digit timeout once the controller is idle, then reads it back.
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DIGIT_TIMEOUT;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        lock_timeout = value;
        timeouts_used++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(value)) begin
            $display("%0t: timeout readback expected %0d, got %0d", $time, value, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One digit as a burst of presses, then enough quiet ticks to close it.
    // Short timeouts only ever give single-press digits.
    task automatic enter_digit(input int value);
        int presses;
        int spread;
        if (lock_timeout < 2) begin
            presses = 1;
            spread  = 0;
        end else begin
            presses = (value == 0) ? 10 : value;
            if ($urandom_range(0, 7) == 0) presses += 10;
            spread = (lock_timeout - 2 < 4) ? lock_timeout - 2 : 4;
        end
        for (int i = 0; i < presses; i++) begin
            if (i > 0) repeat ($urandom_range(0, spread)) push_tick(1'b0, rare_presence());
            push_tick(1'b1, rare_presence());
        end
        repeat (lock_timeout + $urandom_range(1, 3)) push_tick(1'b0, rare_presence());
    endtask

    // Mostly whole codes, correct ones while armed, with noise, lone presence
    // events and broken codes mixed in.
    task automatic random_run(input int count);
        int stop_at;
        int pick;
        stop_at = ticks_queued + count;
        while (ticks_queued < stop_at) begin
            wait (ticks_accepted == ticks_queued);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(3, 25))
                    push_tick($urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
            end else if (pick < 22) begin
                repeat ($urandom_range(1, 2)) enter_digit($urandom_range(0, 9));
            end else if (pick < 30) begin
                push_tick(1'b0, 1'b1);
                repeat ($urandom_range(0, 4)) push_tick(1'b0, 1'b0);
            end else if (entry_count != 0) begin
                // Finish the partial code so the next one starts lined up.
                repeat (CODE_LENGTH - entry_count) enter_digit($urandom_range(0, 9));
            end else if (armed_now && $urandom_range(0, 9) < 7) begin
                for (int i = 0; i < CODE_LENGTH; i++) enter_digit(stored_digits[i]);
            end else begin
                repeat (CODE_LENGTH) enter_digit($urandom_range(0, 9));
            end
        end
    endtask

    initial begin
        int later_timeouts[];

        later_timeouts = '{6, 1, 9, 4, 12, 5, 2};

        // Every input known from the start.
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.button_press  = 1'b0;
        tick_ch.presence_seen = 1'b0;
        result_ch.ready       = 1'b0;

        // Model state after reset.
        lock_timeout     = TIMEOUT_RESET;
        counting         = 1'b0;
        press_total      = '0;
        quiet_ticks      = '0;
        press_latched    = 1'b0;
        presence_latched = 1'b0;
        digit_waiting    = 1'b0;
        waiting_digit    = '0;
        lock_state       = LS_DISARMED;
        clear_entry();
        for (int i = 0; i < CODE_LENGTH; i++) stored_digits[i] = EMPTY_MARK;
        entry_count = 0;
        code_ok     = 1'b0;
        armed_now   = 1'b0;
        alert_now   = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: both input bits at both values under the reset timeout,
        // presence latched while disarmed, a burst left open.
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);

        // Directed at the shortest timeout: the open burst closes at once,
        // presses meet timed-out bursts, a code arms the alarm and the
        // latched presence raises the alert; presence on a closing tick
        // makes a later digit replace one still waiting.
        write_timeout(16'd1);
        repeat (6) push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        repeat (4) push_tick(1'b1, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);

        // Zero timeout, then two ticks.
        write_timeout(16'd0);
        random_run(PHASE_ITEMS);
        write_timeout(16'd2);
        random_run(PHASE_ITEMS);

        // Largest timeout: a burst left open through a quiet stretch, which a
        // shorter timeout then closes on the next tick.
        write_timeout(TIMEOUT_MAX);
        repeat ($urandom_range(2, 12)) push_tick(1'b1, 1'b0);
        repeat (100) push_tick(1'b0, rare_presence());
        write_timeout(16'd3);
        random_run(PHASE_ITEMS);

        foreach (later_timeouts[k]) begin
            write_timeout(later_timeouts[k][TIMEOUT_W-1:0]);
            random_run(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_status.size() != 0) begin
            $display("%0t: %0d predicted words never arrived", $time, predicted_status.size());
            error_count++;
        end

        $display("Run covered %0d ticks under %0d timeout settings, %0d digits closed.",
                 ticks_accepted, timeouts_used, digits_closed);
        $display("Code outcomes: %0d armed, %0d disarmed, %0d rejected, %0d alerts raised.",
                 arms_seen, disarms_seen, rejects_seen, alerts_raised);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
